// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is asserted (active low).
`define CHK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check with no reset qualifier.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CHK_RST(lbl, clk, rst_n, prop, msg)
`define CHK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/csctc_pkg.sv =====
// ----------------------------------------------------------------------------
// csctc_pkg
// Shared types and field widths of the CSC triangle counter.
// ----------------------------------------------------------------------------
package csctc_pkg;

    localparam int ADDR_W = 13;
    localparam int VAL_W  = 14;
    localparam int CNT_W  = 24;
    localparam int VC_W   = 11;
    localparam int NC_W   = 14;
    localparam int OP_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_NONZERO_COUNT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WR_COL = 2'd0,
        OP_WR_ROW = 2'd1,
        OP_RUN    = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLRD,
        ST_COLCHK,
        ST_ROWRD,
        ST_ROWCHK,
        ST_PTR1,
        ST_PTR2,
        ST_MRD,
        ST_MCMP,
        ST_DONE
    } t_state;

endpackage

// ===== src/csctc_ram.sv =====
// ----------------------------------------------------------------------------
// csctc_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module csctc_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== src/csc_triangle_counter.sv =====
// ----------------------------------------------------------------------------
// csc_triangle_counter
// Triangle count over a CSC adjacency matrix by sorted-list intersection.
// ----------------------------------------------------------------------------
// Load items (tuser = write column start / write row index) are taken one per
// cycle while idle and written straight into the column start RAM and the row
// index RAM; both RAMs power up undefined, and the user must load every entry a
// run reads, as the block does not enforce it. A run item makes the sequencer
// walk all nonzeros while the input is held not ready. Per nonzero it makes each
// column advance check, fetches the row index, fetches both list bounds and
// runs the merge steps, then leaves the merge; a row not below the vertex count
// skips the bounds and the merge. The end of the walk is seen and the total is
// posted once any earlier result is taken. The steps follow from the registered
// read ports of the two RAMs and the single merge compare. The total is
// returned as one item on the master side and saturates at 2^24-1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csc_triangle_counter #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_NONZEROS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [12:0] address, [26:13] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] triangle_count
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    localparam int CS_DEPTH = MAX_VERTICES + 1;
    localparam int CS_AW    = $clog2(CS_DEPTH);
    localparam int RS_AW    = $clog2(MAX_NONZEROS);

    localparam int VW = csctc_pkg::VAL_W;
    localparam int CW = csctc_pkg::CNT_W;
    localparam int NW = csctc_pkg::NC_W;
    localparam int XW = csctc_pkg::VC_W;

    csctc_pkg::t_state r_state, n_state;

    logic [XW-1:0] r_vertex_count;
    logic [NW-1:0] r_nonzero_count;

    logic [XW-1:0] r_col,   n_col;
    logic [NW-1:0] r_i,     n_i;
    logic [VW-1:0] r_row,   n_row;
    logic [VW-1:0] r_a,     n_a;
    logic [VW-1:0] r_a_end, n_a_end;
    logic [VW-1:0] r_b,     n_b;
    logic [VW-1:0] r_b_end, n_b_end;
    logic [CW-1:0] r_total, n_total;

    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_data,  n_out_data;

    logic [csctc_pkg::ADDR_W-1:0] in_addr;
    logic [VW-1:0]                in_val;
    csctc_pkg::t_op               in_op;
    logic                         in_acc;

    logic [XW-1:0] nv;
    logic [NW-1:0] nn;
    logic [XW:0]   col_next;

    logic             cs_we, rs_we;
    logic [CS_AW-1:0] cs_ra, cs_rb;
    logic [RS_AW-1:0] rs_ra, rs_rb;
    logic [VW-1:0]    cs_da, cs_db, rs_da, rs_db;
    logic [VW-1:0]    cs_db_clamp;

    assign in_addr = s_axis_tdata[12:0];
    assign in_val  = s_axis_tdata[26:13];
    assign in_op   = csctc_pkg::t_op'(s_axis_tuser);

    assign s_axis_tready = (r_state == csctc_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // effective register values
    assign nv = (r_vertex_count == '0) ? XW'(1) :
                (32'(r_vertex_count) > MAX_VERTICES) ? XW'(MAX_VERTICES) : r_vertex_count;
    assign nn = (32'(r_nonzero_count) > MAX_NONZEROS) ? NW'(MAX_NONZEROS) : r_nonzero_count;

    assign col_next    = {1'b0, r_col} + (XW+1)'(1);
    assign cs_db_clamp = (cs_db > VW'(nn)) ? VW'(nn) : cs_db;

    assign cs_we = in_acc && (in_op == csctc_pkg::OP_WR_COL) && (32'(in_addr) <= MAX_VERTICES);
    assign rs_we = in_acc && (in_op == csctc_pkg::OP_WR_ROW) && (32'(in_addr) < MAX_NONZEROS);

    csctc_ram #(
        .WIDTH (VW),
        .DEPTH (CS_DEPTH),
        .AW    (CS_AW)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_we      (cs_we),
        .i_waddr   (CS_AW'(in_addr)),
        .i_wdata   (in_val),
        .i_raddr_a (cs_ra),
        .i_raddr_b (cs_rb),
        .o_rdata_a (cs_da),
        .o_rdata_b (cs_db)
    );

    csctc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_NONZEROS),
        .AW    (RS_AW)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_we      (rs_we),
        .i_waddr   (RS_AW'(in_addr)),
        .i_wdata   (in_val),
        .i_raddr_a (rs_ra),
        .i_raddr_b (rs_rb),
        .o_rdata_a (rs_da),
        .o_rdata_b (rs_db)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= csctc_pkg::ST_IDLE;
            r_out_valid     <= 1'b0;
            r_vertex_count  <= XW'(1);
            r_nonzero_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    csctc_pkg::CFG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[XW-1:0];
                    csctc_pkg::CFG_NONZERO_COUNT: r_nonzero_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_i        <= n_i;
        r_row      <= n_row;
        r_a        <= n_a;
        r_a_end    <= n_a_end;
        r_b        <= n_b;
        r_b_end    <= n_b_end;
        r_total    <= n_total;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_i         = r_i;
        n_row       = r_row;
        n_a         = r_a;
        n_a_end     = r_a_end;
        n_b         = r_b;
        n_b_end     = r_b_end;
        n_total     = r_total;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        cs_ra       = CS_AW'(col_next);
        cs_rb       = CS_AW'(col_next);
        rs_ra       = RS_AW'(r_i);
        rs_rb       = RS_AW'(r_b);

        case (r_state)
            csctc_pkg::ST_IDLE: begin
                if (in_acc && (in_op == csctc_pkg::OP_RUN)) begin
                    n_col   = '0;
                    n_i     = '0;
                    n_total = '0;
                    n_state = csctc_pkg::ST_COLRD;
                end
            end
            csctc_pkg::ST_COLRD: begin
                if (r_i >= nn) begin
                    n_state = csctc_pkg::ST_DONE;
                end else if (col_next < {1'b0, nv}) begin
                    n_state = csctc_pkg::ST_COLCHK;
                end else begin
                    n_state = csctc_pkg::ST_ROWRD;
                end
            end
            csctc_pkg::ST_COLCHK: begin
                if (cs_da <= VW'(r_i)) begin
                    n_col   = col_next[XW-1:0];
                    n_state = csctc_pkg::ST_COLRD;
                end else begin
                    n_state = csctc_pkg::ST_ROWRD;
                end
            end
            csctc_pkg::ST_ROWRD: begin
                n_state = csctc_pkg::ST_ROWCHK;
            end
            csctc_pkg::ST_ROWCHK: begin
                n_row = rs_da;
                cs_ra = CS_AW'(r_col);
                cs_rb = CS_AW'(col_next);
                if (rs_da >= VW'(nv)) begin
                    n_i     = r_i + NW'(1);
                    n_state = csctc_pkg::ST_COLRD;
                end else begin
                    n_state = csctc_pkg::ST_PTR1;
                end
            end
            csctc_pkg::ST_PTR1: begin
                n_a     = cs_da;
                n_a_end = cs_db_clamp;
                cs_ra   = CS_AW'(r_row);
                cs_rb   = CS_AW'(r_row + VW'(1));
                n_state = csctc_pkg::ST_PTR2;
            end
            csctc_pkg::ST_PTR2: begin
                n_b     = cs_da;
                n_b_end = cs_db_clamp;
                n_state = csctc_pkg::ST_MRD;
            end
            csctc_pkg::ST_MRD: begin
                rs_ra = RS_AW'(r_a);
                rs_rb = RS_AW'(r_b);
                if ((r_a < r_a_end) && (r_b < r_b_end)) begin
                    n_state = csctc_pkg::ST_MCMP;
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = csctc_pkg::ST_COLRD;
                end
            end
            csctc_pkg::ST_MCMP: begin
                if (rs_da > rs_db) begin
                    n_b = r_b + VW'(1);
                end else if (rs_da < rs_db) begin
                    n_a = r_a + VW'(1);
                end else begin
                    n_a     = r_a + VW'(1);
                    n_b     = r_b + VW'(1);
                    n_total = (r_total == csctc_pkg::CNT_MAX) ? r_total : r_total + CW'(1);
                end
                n_state = csctc_pkg::ST_MRD;
            end
            csctc_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_total;
                    n_state     = csctc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csctc_pkg::ST_IDLE;
            end
        endcase
    end

    `CHK_RST(a_run_starts, i_clk, i_rst_n,
             in_acc && (in_op == csctc_pkg::OP_RUN) |=> r_state == csctc_pkg::ST_COLRD,
             "run item did not start the walk")
    `CHK_RST(a_merge_bounds, i_clk, i_rst_n,
             r_state == csctc_pkg::ST_MCMP |-> (r_a < r_a_end) && (r_b < r_b_end),
             "merge step outside list bounds")
    `CHK_RST(a_col_range, i_clk, i_rst_n,
             r_state == csctc_pkg::ST_ROWCHK |-> r_col < nv,
             "current column beyond vertex count")
    `CHK_RST(a_total_grows, i_clk, i_rst_n,
             r_state == csctc_pkg::ST_MCMP |=> r_total >= $past(r_total),
             "running total decreased")
    `CHK_RST(a_done_no_drop, i_clk, i_rst_n,
             r_state == csctc_pkg::ST_DONE && r_out_valid && !m_axis_tready
                 |=> r_state == csctc_pkg::ST_DONE,
             "result overwrote a pending item")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for csc_triangle_counter. Loads small symmetric graphs
// in CSC form, with stray and overwriting loads mixed in, and runs the count.
// Every run's total is predicted in the bench and compared with the returned
// item. It ends with a vertex count above the limit, with lists in the last
// columns.
// ----------------------------------------------------------------------------

localparam int N_VERT = 1024;
localparam int N_NZ   = 8192;

class triangle_tally;
    bit [csctc_pkg::VAL_W-1:0] col_start [0:N_VERT];
    bit [csctc_pkg::VAL_W-1:0] row_idx [0:N_NZ-1];
    bit [csctc_pkg::VC_W-1:0]  vertices = 1;
    bit [csctc_pkg::NC_W-1:0]  nonzeros = 0;
    bit [csctc_pkg::CNT_W-1:0] count_q [$];
    int                        errors = 0;
    int                        checked = 0;

    function void set_reg(logic idx, logic [csctc_pkg::NC_W-1:0] data);
        if (idx == csctc_pkg::CFG_VERTEX_COUNT) begin
            vertices = data[csctc_pkg::VC_W-1:0];
        end else begin
            nonzeros = data;
        end
    endfunction

    function int unsigned shared_rows(int unsigned a, int unsigned a_end,
                                      int unsigned b, int unsigned b_end);
        int unsigned hits;
        hits = 0;
        while (a < a_end && b < b_end) begin
            if (row_idx[a] > row_idx[b]) begin
                b++;
            end else if (row_idx[a] < row_idx[b]) begin
                a++;
            end else begin
                hits++;
                a++;
                b++;
            end
        end
        return hits;
    endfunction

    function bit [csctc_pkg::CNT_W-1:0] count_triangles();
        int unsigned nv, nn, col, r, e1, e2, i;
        longint unsigned total;
        nv = (vertices == 0) ? 1 : ((vertices > N_VERT) ? N_VERT : vertices);
        nn = (nonzeros > N_NZ) ? N_NZ : nonzeros;
        col = 0;
        total = 0;
        for (i = 0; i < nn; i++) begin
            // step to the column that holds nonzero i
            while (col + 1 < nv && col_start[col + 1] <= i) begin
                col++;
            end
            r = row_idx[i];
            if (r < nv) begin
                e1 = (col_start[col + 1] > nn) ? nn : col_start[col + 1];
                e2 = (col_start[r + 1] > nn) ? nn : col_start[r + 1];
                total += shared_rows(col_start[col], e1, col_start[r], e2);
                if (total > csctc_pkg::CNT_MAX) begin
                    total = csctc_pkg::CNT_MAX;
                end
            end
        end
        return total[csctc_pkg::CNT_W-1:0];
    endfunction

    function void note_item(logic [csctc_pkg::OP_W-1:0] op,
                            logic [csctc_pkg::ADDR_W-1:0] addr,
                            logic [csctc_pkg::VAL_W-1:0] val);
        if (op == csctc_pkg::OP_WR_COL) begin
            if (addr <= N_VERT) begin
                col_start[addr] = val;
            end
        end else if (op == csctc_pkg::OP_WR_ROW) begin
            row_idx[addr] = val;
        end else if (op == csctc_pkg::OP_RUN) begin
            count_q.push_back(count_triangles());
        end
    endfunction

    function void check_count(logic [csctc_pkg::CNT_W-1:0] got);
        bit [csctc_pkg::CNT_W-1:0] want;
        if (count_q.size() == 0) begin
            $display("%0t: unexpected count item, expected none actual %0d", $time, got);
            errors++;
        end else begin
            want = count_q.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: count mismatch, expected %0d actual %0d", $time, want, got);
                errors++;
            end
        end
    endfunction

    function int pending();
        return count_q.size();
    endfunction
endclass

module tb_top;
    localparam logic [csctc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 40000;
    localparam int ITEM_GOAL   = 180;
    localparam int RUN_GOAL    = 6;
    localparam longint TIMEOUT_NS = 64'd200_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [12:0] address, [26:13] value
    logic [1:0]  s_axis_tuser = '0;     // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [23:0] triangle_count
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data = '0;

    triangle_tally board;
    bit col_done [0:N_VERT];
    bit row_done [0:N_NZ-1];
    int cur_v = 1;
    int cur_n = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_done = 0;
    int runs_done = 0;
    int hold_reqs = 0;
    int hold_taken = 0;
    int hold_left = 0;

    csc_triangle_counter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check, then pick next ready (long hold on request)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                board.check_count(m_axis_tdata);
            end
            if (hold_reqs != hold_taken) begin
                hold_taken = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(logic [csctc_pkg::OP_W-1:0] op, int unsigned addr_raw,
                             int unsigned val_raw);
        logic [csctc_pkg::ADDR_W-1:0] addr;
        logic [csctc_pkg::VAL_W-1:0]  val;
        addr = addr_raw[csctc_pkg::ADDR_W-1:0];
        val  = val_raw[csctc_pkg::VAL_W-1:0];
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, val, addr};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) begin
            @(posedge i_clk);
        end
        board.note_item(op, addr, val);
        if (op == csctc_pkg::OP_WR_COL && addr <= N_VERT) begin
            col_done[addr] = 1'b1;
            items_done++;
        end else if (op == csctc_pkg::OP_WR_ROW) begin
            row_done[addr] = 1'b1;
            items_done++;
        end else if (op == csctc_pkg::OP_RUN) begin
            items_done++;
            runs_done++;
        end
    endtask

    task automatic stray_item();
        if ($urandom_range(1)) begin
            send_item(OP_UNUSED, $urandom, $urandom_range(8192));
        end else begin
            send_item(csctc_pkg::OP_WR_COL, $urandom_range(N_VERT + 1, N_NZ - 1),
                      $urandom_range(8192));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [csctc_pkg::NC_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic configure(int v_raw, int n_raw);
        wait_idle();
        write_reg(csctc_pkg::CFG_VERTEX_COUNT, v_raw[csctc_pkg::NC_W-1:0]);
        write_reg(csctc_pkg::CFG_NONZERO_COUNT, n_raw[csctc_pkg::NC_W-1:0]);
        i_cfg_we <= 1'b0;
        cur_v = (v_raw == 0) ? 1 : ((v_raw > N_VERT) ? N_VERT : v_raw);
        cur_n = (n_raw > N_NZ) ? N_NZ : n_raw;
    endtask

    // a run may only touch loaded entries
    task automatic fill_gaps();
        for (int c = 0; c <= cur_v; c++) begin
            if (!col_done[c]) begin
                send_item(csctc_pkg::OP_WR_COL, c, $urandom_range(cur_n));
            end
        end
        for (int i = 0; i < cur_n; i++) begin
            if (!row_done[i]) begin
                send_item(csctc_pkg::OP_WR_ROW, i, $urandom_range(cur_v));
            end
        end
    endtask

    task automatic graph_episode(bit squeeze);
        bit adj [0:15][0:15];
        int st [0:15];
        int rows_q [$];
        int nv, dens, m_total, n_raw, pick;
        nv = $urandom_range(1, 14);
        dens = $urandom_range(15, 60);
        for (int i = 0; i < nv; i++) begin
            for (int j = 0; j <= i; j++) begin
                adj[i][j] = (i != j || $urandom_range(9) == 0) && $urandom_range(99) < dens;
                adj[j][i] = adj[i][j];
            end
        end
        for (int c = 0; c < nv; c++) begin
            st[c] = rows_q.size();
            for (int r = 0; r < nv; r++) begin
                if (adj[r][c]) begin
                    rows_q.push_back(r);
                end
            end
            if ($urandom_range(19) == 0) begin
                rows_q.push_back($urandom_range(8192, nv));
            end
        end
        st[nv] = rows_q.size();
        m_total = rows_q.size();
        pick = $urandom_range(9);
        if (pick < 7) begin
            n_raw = m_total;
        end else if (pick < 9) begin
            n_raw = m_total - $urandom_range(m_total < 3 ? m_total : 3);
        end else begin
            n_raw = m_total + $urandom_range(1, 4);
        end
        configure((nv == 1 && $urandom_range(1)) ? 0 : nv, n_raw);
        for (int c = 0; c <= nv; c++) begin
            if ($urandom_range(11) == 0) begin
                stray_item();
            end
            send_item(csctc_pkg::OP_WR_COL, c, st[c]);
        end
        foreach (rows_q[i]) begin
            if ($urandom_range(11) == 0) begin
                stray_item();
            end
            send_item(csctc_pkg::OP_WR_ROW, i, rows_q[i]);
        end
        fill_gaps();
        if (squeeze) begin
            hold_reqs++;
        end
        send_item(csctc_pkg::OP_RUN, $urandom, $urandom_range(8192));
        // result held back: one run waits inside, the next at the input
        if (squeeze) begin
            send_item(csctc_pkg::OP_RUN, $urandom, $urandom_range(8192));
            send_item(csctc_pkg::OP_RUN, $urandom, $urandom_range(8192));
        end
        // corrupt a few entries and count again
        if ($urandom_range(99) < 35) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(1)) begin
                    send_item(csctc_pkg::OP_WR_COL, $urandom_range(cur_v),
                              ($urandom_range(3) == 0) ? $urandom_range(8192)
                                                       : $urandom_range(cur_n + 1));
                end else if (cur_n > 0) begin
                    send_item(csctc_pkg::OP_WR_ROW, $urandom_range(cur_n - 1),
                              $urandom_range(cur_v + 1));
                end
            end
            send_item(csctc_pkg::OP_RUN, $urandom, $urandom_range(8192));
        end
    endtask

    task automatic run_phase(int tx, int rx, int item_goal, int run_goal, bit squeeze);
        int item_base, run_base;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        item_base = items_done;
        run_base = runs_done;
        graph_episode(squeeze);
        while (items_done - item_base < item_goal || runs_done - run_base < run_goal) begin
            graph_episode(1'b0);
        end
    endtask

    task automatic directed_items();
        send_item(csctc_pkg::OP_RUN, 8191, 8192);
        send_item(OP_UNUSED, 8191, 8192);
        send_item(csctc_pkg::OP_WR_COL, 8191, 8192);
        send_item(csctc_pkg::OP_WR_COL, 1025, 5);
        send_item(csctc_pkg::OP_WR_COL, 1024, 0);
        send_item(csctc_pkg::OP_WR_ROW, 8191, 8192);
        configure(4, 8);
        // triangle 0-1-2, vertex 3 with a self loop and an out of range row
        send_item(csctc_pkg::OP_WR_COL, 0, 0);
        send_item(csctc_pkg::OP_WR_COL, 1, 2);
        send_item(csctc_pkg::OP_WR_COL, 2, 4);
        send_item(csctc_pkg::OP_WR_COL, 3, 6);
        send_item(csctc_pkg::OP_WR_COL, 4, 8);
        send_item(csctc_pkg::OP_WR_ROW, 0, 1);
        send_item(csctc_pkg::OP_WR_ROW, 1, 2);
        send_item(csctc_pkg::OP_WR_ROW, 2, 0);
        send_item(csctc_pkg::OP_WR_ROW, 3, 2);
        send_item(csctc_pkg::OP_WR_ROW, 4, 0);
        send_item(csctc_pkg::OP_WR_ROW, 5, 1);
        send_item(csctc_pkg::OP_WR_ROW, 6, 3);
        send_item(csctc_pkg::OP_WR_ROW, 7, 8192);
        send_item(csctc_pkg::OP_RUN, 0, 0);
        // column 0 starts late: leading nonzeros stay in column 0
        send_item(csctc_pkg::OP_WR_COL, 0, 2);
        send_item(csctc_pkg::OP_RUN, 0, 0);
    endtask

    // vertex count above the limit, rows in the last columns
    task automatic wide_vertex_phase();
        configure(2047, 5);
        send_item(csctc_pkg::OP_WR_COL, 0, 0);
        send_item(csctc_pkg::OP_WR_COL, 1, 5);
        send_item(csctc_pkg::OP_WR_COL, 5, 5);
        send_item(csctc_pkg::OP_WR_COL, 6, 5);
        send_item(csctc_pkg::OP_WR_COL, 1000, 0);
        send_item(csctc_pkg::OP_WR_COL, 1001, 2);
        send_item(csctc_pkg::OP_WR_COL, 1023, 2);
        send_item(csctc_pkg::OP_WR_COL, 1024, 9);
        send_item(csctc_pkg::OP_WR_ROW, 0, 0);
        send_item(csctc_pkg::OP_WR_ROW, 1, 5);
        send_item(csctc_pkg::OP_WR_ROW, 2, 1000);
        send_item(csctc_pkg::OP_WR_ROW, 3, 1023);
        send_item(csctc_pkg::OP_WR_ROW, 4, 1024);
        send_item(csctc_pkg::OP_RUN, 0, 0);
        configure(N_VERT, 3);
        send_item(csctc_pkg::OP_RUN, 0, 0);
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 21;
        rx_idle_pct = 71;
        directed_items();
        run_phase(21, 71, ITEM_GOAL, RUN_GOAL, 1'b0);
        run_phase(71, 21, ITEM_GOAL, RUN_GOAL, 1'b1);
        run_phase(0, 0, ITEM_GOAL, RUN_GOAL, 1'b0);
        wide_vertex_phase();
        wait_idle();
        $display("%0d items accepted, %0d runs, %0d counts checked", items_done, runs_done,
                 board.checked);
        $display("loads, ignored items, clamped counts and a held result with a stalled input");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d counts outstanding", board.pending());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
